>>> src/rk4syn_pkg.sv
package rk4syn_pkg;

    // fraction bits of the internal stage values
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int TIME_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int COND_W  = 24;
    localparam int DT_W    = 16;

    // configuration port
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // register reset values
    localparam logic [COND_W-1:0] PEAK_RST = 24'd65536;
    localparam logic [DT_W-1:0]   DT_RST   = 16'd3277;
    localparam logic [TIME_W-1:0] FAT_RST  = 32'd0;

    // transmitter window, 0.3 ms in Q16.16
    localparam int WINDOW_Q16 = 19661;
    localparam int COND_MAX   = 16777215;

    // floor division by three through a reciprocal
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP       = (1 << RECIP_SHIFT) / 3;
    localparam int Z_W         = 20;
    localparam int Q_W         = 18;
    localparam int Z_OFFSET    = 3 * (1 << 17);
    localparam int Q_BIAS      = 1 << 17;

    typedef enum logic [1:0] {
        REG_PEAK = 2'd0,
        REG_DT   = 2'd1,
        REG_FAT  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [COND_W-1:0] peak;
        logic [DT_W-1:0]   dt;
        logic [TIME_W-1:0] fat;
        logic              fat_wr;
    } t_cfg;

endpackage

>>> src/rk4syn_apb.sv
module rk4syn_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rk4syn_pkg::APB_AW-1:0] paddr,
    input  logic [rk4syn_pkg::APB_DW-1:0] pwdata,
    output logic [rk4syn_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    output rk4syn_pkg::t_cfg              o_cfg
);
    import rk4syn_pkg::*;

    logic [COND_W-1:0] r_peak;
    logic [DT_W-1:0]   r_dt;
    logic [TIME_W-1:0] r_fat;
    logic              wr_en;
    logic [1:0]        idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= PEAK_RST;
            r_dt   <= DT_RST;
            r_fat  <= FAT_RST;
        end else begin
            if (wr_en) begin
                unique case (idx)
                    REG_PEAK: r_peak <= pwdata[COND_W-1:0];
                    REG_DT:   r_dt   <= pwdata[DT_W-1:0];
                    REG_FAT:  r_fat  <= pwdata[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            REG_PEAK: prdata = {{(APB_DW-COND_W){1'b0}}, r_peak};
            REG_DT:   prdata = {{(APB_DW-DT_W){1'b0}}, r_dt};
            REG_FAT:  prdata = r_fat;
            default:  prdata = '0;
        endcase
    end

    // activation time load fires at the write edge, with the written value
    assign o_cfg.peak   = r_peak;
    assign o_cfg.dt     = r_dt;
    assign o_cfg.fat    = pwdata[TIME_W-1:0];
    assign o_cfg.fat_wr = wr_en && (idx == REG_FAT);

endmodule

>>> src/rk4syn_mul.sv
module rk4syn_mul #(
    parameter int MA = 25,
    parameter int MB = 22
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [MA-1:0]    i_a,
    input  logic signed [MB-1:0]    i_b,
    output logic signed [MA+MB-1:0] o_p
);

    logic signed [MA+MB-1:0] r_p;

    // product register, held while idle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

>>> src/synapse_open_fraction_rk4.sv
// kinetic synapse gating, one four-stage runge-kutta step per transaction
//
// slave stream: s_axis_tdata carries the step time and the offered next
// activation time, s_axis_tuser flags the offer. the block takes a new
// activation time when the step time is more than 0.3 ms past the current
// one and an offer is present, then integrates the open fraction.
// master stream: g times each stage fraction and the new open fraction on
// m_axis_tdata, activation_taken on m_axis_tuser.
// one signed multiplier is shared by every product under a small sequencer:
// each of the four stages steps through dw, oci, gprod, bprod, aprod and
// rate, then sum, dtmul, zoff, recip, corr and done form the final update;
// the next item is taken only once the sequencer is back in idle.
// a stalled receiver holds the result in the output register; the block
// then takes one more item and waits at its last step until the register
// frees up, so the open fraction is never updated ahead of delivery.
// reset (synchronous, active low) clears the open fraction, loads the
// activation time from first_activation_time and restores the registers.
// apb writes belong between transactions with nothing in flight; writing
// first_activation_time also loads the current activation time at once.
module synapse_open_fraction_rk4 #(
    parameter int FRAC_BITS = rk4syn_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] step_time, [63:32] next_activation_time
    input  logic [63:0]                   s_axis_tdata,
    // [0] next_activation_valid
    input  logic                          s_axis_tuser,
    // master stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [23:0] stage_zero_conductance, [47:24] stage_one_conductance,
    // [71:48] stage_two_conductance, [95:72] stage_three_conductance,
    // [111:96] open_fraction_out
    output logic [111:0]                  m_axis_tdata,
    // [0] activation_taken
    output logic                          m_axis_tuser,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rk4syn_pkg::APB_AW-1:0] paddr,
    input  logic [rk4syn_pkg::APB_DW-1:0] pwdata,
    output logic [rk4syn_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);
    import rk4syn_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int OW  = F + 3;               // stage fraction and rate
    localparam int SW  = OW + 3;              // weighted rate sum
    localparam int MA  = 25;
    localparam int MB  = (SW > Z_W + 1) ? SW : Z_W + 1;
    localparam int PW  = MA + MB;
    localparam longint ONE_F   = longint'(1) << F;
    localparam longint ALPHA_F = (94 * ONE_F + 50) / 100;
    localparam longint BETA_F  = (18 * ONE_F + 50) / 100;

    typedef enum logic [3:0] {
        S_IDLE, S_DW, S_OCI, S_GPROD, S_BPROD, S_APROD, S_RATE,
        S_SUM, S_DTMUL, S_ZOFF, S_RECIP, S_CORR, S_DONE
    } t_state;

    t_cfg cfg;

    t_state                  r_state;
    logic [1:0]              r_stage;
    logic [TIME_W-1:0]       r_t;
    logic [TIME_W-1:0]       r_act;
    logic                    r_taken;
    logic [FRAC_W-1:0]       r_of;
    logic signed [OW-1:0]    r_oci;
    logic signed [OW-1:0]    r_omo;
    logic signed [OW-1:0]    r_rb;
    logic signed [OW-1:0]    r_k [4];
    logic [COND_W-1:0]       r_cond [4];
    logic signed [SW-1:0]    r_sum;
    logic [Z_W-1:0]          r_z;
    logic [Q_W-1:0]          r_q;
    logic                    r_ovalid;
    logic [111:0]            r_odata;
    logic                    r_ouser;

    // multiplier operands
    logic                    mul_en;
    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PW-1:0]    prod;

    // datapath helpers
    logic                    in_acc;
    logic                    take;
    logic [F+FRAC_W-1:0]     ocx;
    logic signed [OW-1:0]    oc_f;
    logic [DT_W:0]           w2;
    logic [TIME_W+1:0]       ti2;
    logic [TIME_W+1:0]       act2;
    logic [TIME_W+1:0]       act2_hi;
    logic                    win;
    logic signed [PW-1:0]    sh17;
    logic signed [PW-1:0]    shf;
    logic signed [PW-1:0]    shf1;
    logic [COND_W-1:0]       cond_c;
    logic signed [SW-1:0]    k_sum;
    logic [Q_W-1:0]          qe;
    logic [Z_W:0]            rem;
    logic signed [Q_W+1:0]   nsum;
    logic [FRAC_W-1:0]       of_new;

    rk4syn_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rk4syn_mul #(
        .MA (MA),
        .MB (MB)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // new activation when t - act exceeds the window and an offer is there
    assign take = s_axis_tuser &&
                  ({1'b0, s_axis_tdata[31:0]} >
                   ({1'b0, r_act} + (TIME_W+1)'(WINDOW_Q16)));

    // open fraction rescaled to F fraction bits, floor
    assign ocx  = {r_of, {F{1'b0}}};
    assign oc_f = {3'b000, ocx[F+FRAC_W-1:FRAC_W]};

    // stage offsets in half-lsb units: 0, dt, dt, 2dt
    always_comb begin
        unique case (r_stage)
            2'd0:    w2 = '0;
            2'd3:    w2 = {cfg.dt, 1'b0};
            default: w2 = {1'b0, cfg.dt};
        endcase
    end

    // transmitter pulse window on the stage time
    assign ti2     = {1'b0, r_t, 1'b0} + {{(TIME_W+1-DT_W){1'b0}}, w2};
    assign act2    = {1'b0, r_act, 1'b0};
    assign act2_hi = act2 + (TIME_W+2)'(2 * WINDOW_Q16);
    assign win     = (ti2 >= act2) && (ti2 <= act2_hi);

    assign sh17 = prod >>> 17;
    assign shf  = prod >>> F;
    assign shf1 = prod >>> (F + 1);

    always_comb begin
        if (shf < 0) begin
            cond_c = '0;
        end else if (shf > PW'(COND_MAX)) begin
            cond_c = COND_W'(COND_MAX);
        end else begin
            cond_c = shf[COND_W-1:0];
        end
    end

    assign k_sum = SW'(r_k[0]) + SW'(r_k[3]) + ((SW'(r_k[1]) + SW'(r_k[2])) <<< 1);

    // quotient estimate and its remainder, at most one short
    assign qe  = prod[RECIP_SHIFT +: Q_W];
    assign rem = {1'b0, r_z} - ({3'b000, qe} + {2'b00, qe, 1'b0});

    // new open fraction, saturated
    assign nsum = $signed({4'b0000, r_of}) + $signed({2'b00, r_q}) - (Q_W+2)'(Q_BIAS);
    always_comb begin
        if (nsum < 0) begin
            of_new = '0;
        end else if (nsum > (Q_W+2)'(65535)) begin
            of_new = '1;
        end else begin
            of_new = nsum[FRAC_W-1:0];
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_DW: begin
                mul_a = {{(MA-DT_W-1){1'b0}}, w2};
                mul_b = MB'(r_k[r_stage + 2'd3]);
            end
            S_GPROD: begin
                mul_a = {1'b0, cfg.peak};
                mul_b = MB'(r_oci);
            end
            S_BPROD: begin
                mul_a = MA'(BETA_F);
                mul_b = MB'(r_oci);
            end
            S_APROD: begin
                mul_a = MA'(ALPHA_F);
                mul_b = MB'(r_omo);
            end
            S_DTMUL: begin
                mul_a = {{(MA-DT_W){1'b0}}, cfg.dt};
                mul_b = MB'(r_sum);
            end
            S_RECIP: begin
                mul_a = MA'(RECIP);
                mul_b = {{(MB-Z_W){1'b0}}, r_z};
            end
            default: mul_en = 1'b0;
        endcase
    end

    // sequencer, state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stage  <= '0;
            r_act    <= FAT_RST;
            r_of     <= '0;
            r_k      <= '{default: '0};
            r_ovalid <= 1'b0;
        end else begin
            // drained result, unless a new one is loaded in this cycle
            if (r_ovalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            // an accepted offer overrides a register load at the same edge
            if (cfg.fat_wr && !(in_acc && take)) begin
                r_act <= cfg.fat;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_t     <= s_axis_tdata[31:0];
                        r_taken <= take;
                        r_stage <= '0;
                        if (take) begin
                            r_act <= s_axis_tdata[63:32];
                        end
                        r_state <= S_DW;
                    end
                end
                S_DW: begin
                    r_state <= S_OCI;
                end
                S_OCI: begin
                    r_oci   <= oc_f + sh17[OW-1:0];
                    r_state <= S_GPROD;
                end
                S_GPROD: begin
                    r_omo   <= OW'(ONE_F) - r_oci;
                    r_state <= S_BPROD;
                end
                S_BPROD: begin
                    r_cond[r_stage] <= cond_c;
                    r_state         <= S_APROD;
                end
                S_APROD: begin
                    r_rb    <= shf[OW-1:0];
                    r_state <= S_RATE;
                end
                S_RATE: begin
                    r_k[r_stage] <= (win ? shf1[OW-1:0] : OW'(0)) - r_rb;
                    if (r_stage == 2'd3) begin
                        r_state <= S_SUM;
                    end else begin
                        r_stage <= r_stage + 2'd1;
                        r_state <= S_DW;
                    end
                end
                S_SUM: begin
                    r_sum   <= k_sum;
                    r_state <= S_DTMUL;
                end
                S_DTMUL: begin
                    r_state <= S_ZOFF;
                end
                S_ZOFF: begin
                    // floor by 2^(F+1), biased positive for the divide by three
                    r_z     <= shf1[Z_W-1:0] + Z_W'(Z_OFFSET);
                    r_state <= S_RECIP;
                end
                S_RECIP: begin
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    r_q     <= qe + {{(Q_W-1){1'b0}}, (rem >= (Z_W+1)'(3))};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_of     <= of_new;
                        r_odata  <= {of_new, r_cond[3], r_cond[2], r_cond[1], r_cond[0]};
                        r_ouser  <= r_taken;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> verif/synapse_gate_checker.sv
module synapse_gate_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [63:0]                   i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [111:0]                  i_m_tdata,
    input  logic                          i_m_tuser,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [rk4syn_pkg::APB_AW-1:0] i_paddr,
    input  logic [rk4syn_pkg::APB_DW-1:0] i_pwdata,
    input  logic [rk4syn_pkg::APB_DW-1:0] i_prdata,
    input  logic                          i_pready,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_handovers
);
    import rk4syn_pkg::*;

    localparam int     FB       = FRAC_BITS_DEF;
    localparam longint ONE_FX   = longint'(1) << FB;
    localparam longint ALPHA_FX = (94 * ONE_FX + 50) / 100;
    localparam longint BETA_FX  = (18 * ONE_FX + 50) / 100;
    localparam int     DUE_DEPTH = 8;

    typedef struct packed {
        logic [3:0][COND_W-1:0] stage_cond;
        logic [FRAC_W-1:0]      open_frac;
        logic                   taken;
    } t_gate_result;

    logic [COND_W-1:0] cfg_peak;
    logic [DT_W-1:0]   cfg_dt;
    logic [TIME_W-1:0] cfg_fat;
    logic [FRAC_W-1:0] open_frac;
    logic [TIME_W-1:0] act_time;

    // results still owed by the block, oldest at due_rd
    t_gate_result due_mem [DUE_DEPTH];
    int           due_rd        = 0;
    int           due_wr        = 0;
    int           due_cnt       = 0;
    int           err_cnt       = 0;
    int           pending_cnt   = 0;
    int           checked_cnt   = 0;
    int           handover_cnt  = 0;

    assign o_errors    = err_cnt;
    assign o_pending   = pending_cnt;
    assign o_checked   = checked_cnt;
    assign o_handovers = handover_cnt;

    function automatic longint clamp_hi(longint x, longint hi);
        if (x < 0) return 0;
        if (x > hi) return hi;
        return x;
    endfunction

    // division rounding toward minus infinity
    function automatic longint div_floor(longint x, longint d);
        if (x >= 0) return x / d;
        return -((-(x + 1)) / d) - 1;
    endfunction

    // one rk4 step of the open fraction, updates the gating state
    function automatic t_gate_result predict_gate_step(logic [TIME_W-1:0] t,
                                                       logic [TIME_W-1:0] offered,
                                                       logic ofr);
        t_gate_result res;
        longint tl, actl, ocl, ocf, oci, peakl, rate, sum, delta;
        longint ofs2 [4];
        longint kr [4];
        int     i;
        tl   = {32'd0, t};
        actl = {32'd0, act_time};
        res.taken = 1'b0;
        if (tl - actl > WINDOW_Q16 && ofr) begin
            act_time  = offered;
            res.taken = 1'b1;
        end
        actl    = {32'd0, act_time};
        peakl   = {40'd0, cfg_peak};
        ocl     = {48'd0, open_frac};
        ofs2[0] = 0;
        ofs2[1] = {48'd0, cfg_dt};
        ofs2[2] = ofs2[1];
        ofs2[3] = 2 * ofs2[1];
        ocf     = (ocl << FB) >>> 16;
        for (i = 0; i < 4; i++) kr[i] = 0;
        for (i = 0; i < 4; i++) begin
            oci  = ocf + ((ofs2[i] * kr[(i + 3) % 4]) >>> 17);
            rate = -((BETA_FX * oci) >>> FB);
            // transmitter pulse while the stage time is inside the window
            if (2 * tl + ofs2[i] >= 2 * actl && 2 * tl + ofs2[i] <= 2 * actl + 2 * WINDOW_Q16)
                rate += (ALPHA_FX * (ONE_FX - oci)) >>> (FB + 1);
            kr[i] = rate;
            res.stage_cond[i] = COND_W'(clamp_hi((peakl * oci) >>> FB, COND_MAX));
        end
        sum       = kr[0] + 2 * kr[1] + 2 * kr[2] + kr[3];
        delta     = div_floor(ofs2[1] * sum, 6 * ONE_FX);
        open_frac = FRAC_W'(clamp_hi(ocl + delta, (1 << FRAC_W) - 1));
        res.open_frac = open_frac;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_gate_result want;
        logic [APB_DW-1:0] rd_want;
        logic              rd_known;
        int                i;
        if (!i_rst_n) begin
            cfg_peak  = PEAK_RST;
            cfg_dt    = DT_RST;
            cfg_fat   = FAT_RST;
            open_frac = '0;
            act_time  = FAT_RST;
            due_rd    = 0;
            due_wr    = 0;
            due_cnt   = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[APB_AW-1:2]))
                        REG_PEAK: cfg_peak = i_pwdata[COND_W-1:0];
                        REG_DT:   cfg_dt   = i_pwdata[DT_W-1:0];
                        REG_FAT: begin
                            cfg_fat  = i_pwdata[TIME_W-1:0];
                            act_time = cfg_fat;
                        end
                        default: ;
                    endcase
                end else begin
                    rd_known = 1'b1;
                    case (t_reg_idx'(i_paddr[APB_AW-1:2]))
                        REG_PEAK: rd_want = APB_DW'(cfg_peak);
                        REG_DT:   rd_want = APB_DW'(cfg_dt);
                        REG_FAT:  rd_want = APB_DW'(cfg_fat);
                        default: begin
                            rd_want  = '0;
                            rd_known = 1'b0;
                        end
                    endcase
                    if (rd_known && i_prdata !== rd_want) begin
                        err_cnt++;
                        $display("%0t: register read at %h expected %h got %h",
                                 $time, i_paddr, rd_want, i_prdata);
                    end
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (due_cnt == 0) begin
                    err_cnt++;
                    $display("%0t: result with nothing expected, expected none got %h",
                             $time, i_m_tdata);
                end else begin
                    want    = due_mem[due_rd];
                    due_rd  = (due_rd + 1) % DUE_DEPTH;
                    due_cnt--;
                    checked_cnt++;
                    for (i = 0; i < 4; i++) begin
                        if (i_m_tdata[COND_W*i +: COND_W] !== want.stage_cond[i]) begin
                            err_cnt++;
                            $display("%0t: stage %0d conductance expected %h got %h", $time,
                                     i, want.stage_cond[i], i_m_tdata[COND_W*i +: COND_W]);
                        end
                    end
                    if (i_m_tdata[4*COND_W +: FRAC_W] !== want.open_frac) begin
                        err_cnt++;
                        $display("%0t: open fraction expected %h got %h", $time,
                                 want.open_frac, i_m_tdata[4*COND_W +: FRAC_W]);
                    end
                    if (i_m_tuser !== want.taken) begin
                        err_cnt++;
                        $display("%0t: activation taken expected %b got %b", $time,
                                 want.taken, i_m_tuser);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = predict_gate_step(i_s_tdata[31:0], i_s_tdata[63:32], i_s_tuser);
                if (want.taken) handover_cnt++;
                if (due_cnt == DUE_DEPTH) begin
                    err_cnt++;
                    $display("%0t: outstanding results expected at most %0d got %0d",
                             $time, DUE_DEPTH, due_cnt + 1);
                end else begin
                    due_mem[due_wr] = want;
                    due_wr          = (due_wr + 1) % DUE_DEPTH;
                    due_cnt++;
                end
            end
        end
        pending_cnt = due_cnt;
    end

endmodule

>>> verif/synapse_open_fraction_rk4_tb.sv
module synapse_open_fraction_rk4_tb;

    import rk4syn_pkg::*;

    // cycles without any accepted transaction before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // fourth register slot, not decoded by the block
    localparam logic [APB_AW-1:0] SPARE_ADDR = 4'hC;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // [31:0] step_time, [63:32] next_activation_time
    logic [63:0]       s_axis_tdata  = '0;
    // [0] next_activation_valid
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [23:0] stage 0, [47:24] stage 1, [71:48] stage 2, [95:72] stage 3 conductance,
    // [111:96] open_fraction_out
    logic [111:0]      m_axis_tdata;
    // [0] activation_taken
    logic              m_axis_tuser;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_handovers;

    // stimulus bookkeeping
    int          n_sent       = 0;
    int          quiet_left   = 0;
    int          stall_cycles = 0;
    int          rdy_hold     = 0;
    int          rdy_roll;
    logic [31:0] cursor       = '0;   // simulation time of the well-formed stream
    logic [31:0] act_sh       = '0;   // rough copy of the activation time, for steering only

    synapse_open_fraction_rk4 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    synapse_gate_checker gate_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked),
        .o_handovers (chk_handovers)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver: long ready stretches, short stalls, now and then a long one
    always @(posedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            rdy_roll = $urandom_range(0, 99);
            if (rdy_roll < 20) begin
                m_axis_tready <= 1'b1;
                rdy_hold      <= $urandom_range(40, 200);
            end else if (rdy_roll < 60) begin
                m_axis_tready <= 1'b1;
                rdy_hold      <= $urandom_range(0, 6);
            end else if (rdy_roll < 93) begin
                m_axis_tready <= 1'b0;
                rdy_hold      <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                rdy_hold      <= $urandom_range(20, 80);
            end
        end
    end

    // watchdog on cycles where no transaction of any kind completes
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("synapse_open_fraction_rk4_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [APB_AW-1:0] reg_addr(t_reg_idx idx);
        return {idx, 2'b00};
    endfunction

    // sender gap: mostly none or short, sometimes long, with stretches of back-to-back steps
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 70);
    endfunction

    // one apb transfer: setup, access held until pready, then idle
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // writes all three registers and reads them back
    task automatic set_config(input logic [31:0] peak, dt, fat);
        apb_access(1'b1, reg_addr(REG_PEAK), peak);
        apb_access(1'b1, reg_addr(REG_DT), dt);
        apb_access(1'b1, reg_addr(REG_FAT), fat);
        apb_access(1'b0, reg_addr(REG_PEAK), '0);
        apb_access(1'b0, reg_addr(REG_DT), '0);
        apb_access(1'b0, reg_addr(REG_FAT), '0);
        act_sh = fat;
    endtask

    // one step transaction followed by a random sender gap; valid stays high
    // across back-to-back transactions
    task automatic send_step(input logic [31:0] t, nxt, input logic ofr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt, t};
        s_axis_tuser  <= ofr;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        if (ofr && longint'({32'd0, t}) - longint'({32'd0, act_sh}) > WINDOW_Q16)
            act_sh = nxt;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let every accepted step come back before touching the registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    // one register setting, then mostly time-ordered steps with offers ahead
    // of the current time, mixed with fully random transactions
    task automatic run_phase(input logic [31:0] peak, dt, fat, input int n_items);
        logic [31:0] t, nxt;
        logic        ofr;
        int          k;
        drain();
        set_config(peak, dt, fat);
        cursor = fat - $urandom_range(0, 30000);
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 15) begin
                t   = $urandom;
                nxt = $urandom;
                ofr = $urandom_range(0, 1);
            end else begin
                // fall back near the activation time when far behind it
                if (int'(act_sh - cursor) > 400000)
                    cursor = act_sh - $urandom_range(0, 20000);
                else if ($urandom_range(0, 19) == 0)
                    cursor = cursor + $urandom_range(0, 200000);
                else
                    cursor = cursor + $urandom_range(1, 6554);
                t   = cursor;
                ofr = ($urandom_range(0, 3) == 0);
                nxt = ofr ? cursor + $urandom_range(0, 120000) : $urandom;
            end
            send_step(t, nxt, ofr);
        end
    endtask

    initial begin
        act_sh = FAT_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values read back
        apb_access(1'b0, reg_addr(REG_PEAK), '0);
        apb_access(1'b0, reg_addr(REG_DT), '0);
        apb_access(1'b0, reg_addr(REG_FAT), '0);

        // directed steps under reset settings, activation time at zero
        send_step(32'd0, 32'd0, 1'b0);
        send_step(32'd3277, 32'hFFFF_FFFF, 1'b0);                // no offer
        send_step(WINDOW_Q16, 32'h0000_8000, 1'b1);              // exactly at window end, kept
        send_step(WINDOW_Q16 + 1, 32'h0000_C000, 1'b1);          // just past, taken
        send_step(WINDOW_Q16 + 2, 32'd0, 1'b1);                  // before activation, kept
        send_step(32'h0000_C000, 32'd0, 1'b0);                   // at activation time
        send_step(32'h0000_C000 + WINDOW_Q16 - 3277, 32'd0, 1'b0); // last stage exactly at window end
        send_step(32'h0000_C000 + WINDOW_Q16 + 1, 32'h1234_5678, 1'b0);
        send_step(32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1);           // top of range, taken
        send_step(32'hFFFF_0000 - 3277, 32'd0, 1'b0);            // only last stage in window
        send_step(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_step(32'd0, 32'h8000_0000, 1'b1);                   // far before activation

        // zero time step, full conductance, upper pwdata bits set
        drain();
        set_config(32'hFFFF_FFFF, 32'hA5A5_0000, 32'h0001_0000);
        send_step(32'h0001_0000, 32'd0, 1'b0);
        send_step(32'h0001_0000 + WINDOW_Q16 + 1, 32'h0002_0000, 1'b1);
        send_step(32'h0002_0000, 32'd0, 1'b0);

        // longest time step, zero conductance, write to the unused slot
        drain();
        set_config(32'd0, 32'h0000_FFFF, 32'd0);
        apb_access(1'b1, SPARE_ADDR, 32'hDEAD_BEEF);
        send_step(32'd0, 32'd0, 1'b0);
        send_step(32'h0000_8000, 32'hFFFF_FFFF, 1'b1);

        // shortest nonzero time step
        drain();
        set_config(32'h00FF_FFFF, 32'd1, 32'd0);
        send_step(32'd0, 32'd0, 1'b0);

        // random part over several register settings, extremes among them
        run_phase(32'(PEAK_RST), 32'(DT_RST), $urandom, 108);
        run_phase(32'h00FF_FFFF, 32'h0000_FFFF, 32'd0, 108);
        run_phase(32'd0, 32'd1, 32'hFFFF_FFFF, 108);
        run_phase($urandom, 32'h5A5A_0000, $urandom, 108);
        run_phase($urandom, $urandom_range(1, 8000), $urandom, 108);
        run_phase($urandom, $urandom, $urandom, 108);

        drain();
        repeat (40) @(posedge i_clk);

        $display("covered %0d step transactions, %0d results checked, %0d activation handovers",
                 n_sent, chk_checked, chk_handovers);
        $display("settings: reset values, zero and full time step, zero and full conductance");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("synapse_open_fraction_rk4_tb: PASS");
        end else begin
            $display("synapse_open_fraction_rk4_tb: FAIL");
        end
        $finish;
    end

endmodule
